### hw/rtl/adcss_pkg.sv
// ----------------------------------------------------------------------------
// adcss_pkg
// Shared types, codes and helpers for the ADC scan sequencer.
// ----------------------------------------------------------------------------
package adcss_pkg;

    localparam int MAX_OPTICS_CHANNELS = 2;
    localparam int OPTICS_INPUT_REGS   = 2;
    localparam int OPTICS_CAP          = (MAX_OPTICS_CHANNELS < OPTICS_INPUT_REGS) ?
                                         MAX_OPTICS_CHANNELS : OPTICS_INPUT_REGS;

    localparam int VALUE_W = 32;
    localparam int INPUT_W = 3;
    localparam int SRC_W   = 2;
    localparam int CNT_W   = 2;
    localparam int IDX_W   = 2;
    localparam int CFG_W   = 3;

    // scan sources
    localparam logic [SRC_W-1:0] SRC_ZONE1  = 2'd0;
    localparam logic [SRC_W-1:0] SRC_ZONE2  = 2'd1;
    localparam logic [SRC_W-1:0] SRC_OPTICS = 2'd2;
    localparam logic [SRC_W-1:0] SRC_LID    = 2'd3;

    // fixed adc inputs
    localparam logic [INPUT_W-1:0] ZONE1_INPUT = 3'd0;
    localparam logic [INPUT_W-1:0] ZONE2_INPUT = 3'd1;
    localparam logic [INPUT_W-1:0] LID_INPUT   = 3'd7;

    // register indexes
    localparam logic [IDX_W-1:0] CFG_OPTICS_COUNT  = 2'd0;
    localparam logic [IDX_W-1:0] CFG_OPTICS_FIRST  = 2'd1;
    localparam logic [IDX_W-1:0] CFG_OPTICS_SECOND = 2'd2;

    typedef struct packed {
        logic [CNT_W-1:0]   optics_channel_count;
        logic [INPUT_W-1:0] optics_input_first;
        logic [INPUT_W-1:0] optics_input_second;
    } t_cfg;

    typedef struct packed {
        logic [SRC_W-1:0] src;
        logic             ch;
        logic             discard;
    } t_state;

    typedef struct packed {
        logic [INPUT_W-1:0]        start_input;
        logic                      cycle_start;
        logic                      deliver_valid;
        logic [SRC_W-1:0]          deliver_source;
        logic                      deliver_optics_channel;
        logic signed [VALUE_W-1:0] deliver_value;
    } t_result;

    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] cnt);
        logic [CNT_W-1:0] cap;
        cap = CNT_W'(OPTICS_CAP);
        return (cnt > cap) ? cap : cnt;
    endfunction

endpackage

### hw/rtl/adcss_cfg_regs.sv
// ----------------------------------------------------------------------------
// adcss_cfg_regs
// Configuration registers: optics channel count and optics adc inputs.
// ----------------------------------------------------------------------------
module adcss_cfg_regs
    import adcss_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    output t_cfg             o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_OPTICS_COUNT:  n_cfg.optics_channel_count = i_cfg_wdata[CNT_W-1:0];
                CFG_OPTICS_FIRST:  n_cfg.optics_input_first   = i_cfg_wdata[INPUT_W-1:0];
                CFG_OPTICS_SECOND: n_cfg.optics_input_second  = i_cfg_wdata[INPUT_W-1:0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.optics_channel_count <= 2'd1;
            r_cfg.optics_input_first   <= 3'd2;
            r_cfg.optics_input_second  <= 3'd3;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

### hw/rtl/adcss_step.sv
// ----------------------------------------------------------------------------
// adcss_step
// Next conversion choice, dummy read handling and result tagging for one beat.
// ----------------------------------------------------------------------------
module adcss_step
    import adcss_pkg::*;
(
    input  t_cfg                      i_cfg,
    input  t_state                    i_state,
    input  logic signed [VALUE_W-1:0] i_value,
    input  logic                      i_conv_ready,
    output t_result                   o_result,
    output t_state                    o_next_state
);

    logic             adv_optics;
    logic [SRC_W-1:0] next_src;
    logic             next_ch;
    logic             dummy;
    logic             deliver;

    always_comb begin
        adv_optics = (i_state.src == SRC_OPTICS) &&
                     (({1'b0, i_state.ch} + 2'd1) < eff_count(i_cfg.optics_channel_count));
        next_src   = adv_optics ? SRC_OPTICS : i_state.src + 2'd1;
        next_ch    = adv_optics ? i_state.ch + 1'b1 : 1'b0;
        dummy      = (i_state.src == SRC_ZONE2) && (next_src == SRC_OPTICS) &&
                     !i_state.discard;
        deliver    = i_conv_ready && !i_state.discard;

        unique case (next_src)
            SRC_ZONE1:  o_result.start_input = ZONE1_INPUT;
            SRC_ZONE2:  o_result.start_input = ZONE2_INPUT;
            SRC_OPTICS: o_result.start_input = (!dummy && next_ch) ?
                                               i_cfg.optics_input_second :
                                               i_cfg.optics_input_first;
            default:    o_result.start_input = LID_INPUT;
        endcase
        o_result.cycle_start            = (next_src == SRC_ZONE1);
        o_result.deliver_valid          = deliver;
        o_result.deliver_source         = deliver ? i_state.src : SRC_ZONE1;
        o_result.deliver_optics_channel = deliver && (i_state.src == SRC_OPTICS) &&
                                          i_state.ch;
        o_result.deliver_value          = deliver ? i_value : '0;

        o_next_state = i_state;
        if (i_conv_ready) begin
            if (dummy) begin
                o_next_state.discard = 1'b1;
            end else begin
                o_next_state.discard = 1'b0;
                o_next_state.src     = next_src;
                o_next_state.ch      = next_ch;
            end
        end
    end

endmodule

### hw/rtl/adc_scan_sequencer_unit.sv
// an accepted input beat's result beat is registered and shown in the next cycle
// throughput: one beat per cycle while the result beat is taken; the result register frees as it is taken
// the step logic needs only the scan state from earlier beats, so beats follow back to back
// reset (synchronous, active low): scan state to zone one, channel zero,
//   no discard pending; config registers to count 1, inputs 2 and 3
// ----------------------------------------------------------------------------
// adc_scan_sequencer_unit
// Scan sequencer for a multiplexed adc: chooses the next input and tags results.
// ----------------------------------------------------------------------------
module adc_scan_sequencer_unit
    import adcss_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [IDX_W-1:0]          i_cfg_idx,
    input  logic [CFG_W-1:0]          i_cfg_wdata,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic signed [VALUE_W-1:0] i_conversion_value,
    input  logic                      i_conversion_ready,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [INPUT_W-1:0]        o_start_input,
    output logic                      o_cycle_start,
    output logic                      o_deliver_valid,
    output logic [SRC_W-1:0]          o_deliver_source,
    output logic                      o_deliver_optics_channel,
    output logic signed [VALUE_W-1:0] o_deliver_value
);

    t_cfg    cfg;
    t_state  r_state;
    t_state  n_state;
    t_result r_res;
    t_result step_res;
    logic    r_out_valid;
    logic    in_fire;

    adcss_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    adcss_step u_step (
        .i_cfg        (cfg),
        .i_state      (r_state),
        .i_value      (i_conversion_value),
        .i_conv_ready (i_conversion_ready),
        .o_result     (step_res),
        .o_next_state (n_state)
    );

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.src     <= SRC_ZONE1;
            r_state.ch      <= 1'b0;
            r_state.discard <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (in_fire) begin
                r_state <= n_state;
            end
            if (o_in_ready) begin
                r_out_valid <= i_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_res <= step_res;
        end
    end

    assign o_out_valid              = r_out_valid;
    assign o_start_input            = r_res.start_input;
    assign o_cycle_start            = r_res.cycle_start;
    assign o_deliver_valid          = r_res.deliver_valid;
    assign o_deliver_source         = r_res.deliver_source;
    assign o_deliver_optics_channel = r_res.deliver_optics_channel;
    assign o_deliver_value          = r_res.deliver_value;

endmodule

### hw/rtl/adcss_checker.sv
// ----------------------------------------------------------------------------
// adcss_checker
// Port-level checks for the ADC scan sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module adcss_checker
    import adcss_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_in_ready,
    input logic                      o_out_valid,
    input logic                      i_out_ready,
    input logic [INPUT_W-1:0]        o_start_input,
    input logic                      o_cycle_start,
    input logic                      o_deliver_valid,
    input logic [SRC_W-1:0]          o_deliver_source,
    input logic                      o_deliver_optics_channel,
    input logic signed [VALUE_W-1:0] o_deliver_value
);

    // held result beat keeps its start input and value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_start_input) && $stable(o_deliver_value))
        else $error("result beat changed while stalled");

    // empty output side always takes a beat
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

    // undelivered result carries zero fields
    a_no_deliver_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_deliver_valid |->
            o_deliver_source == SRC_ZONE1 && !o_deliver_optics_channel &&
            o_deliver_value == '0)
        else $error("undelivered result with nonzero fields");

    // optics channel only tagged on optics results
    a_channel_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_deliver_optics_channel |->
            o_deliver_valid && o_deliver_source == SRC_OPTICS)
        else $error("optics channel tag on non-optics result");

    // a new scan cycle always starts on zone one input
    a_cycle_start_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_cycle_start |-> o_start_input == ZONE1_INPUT)
        else $error("cycle start on wrong adc input");

endmodule

bind adc_scan_sequencer_unit adcss_checker u_adcss_checker (
    .i_clk                    (i_clk),
    .i_rst_n                  (i_rst_n),
    .o_in_ready               (o_in_ready),
    .o_out_valid              (o_out_valid),
    .i_out_ready              (i_out_ready),
    .o_start_input            (o_start_input),
    .o_cycle_start            (o_cycle_start),
    .o_deliver_valid          (o_deliver_valid),
    .o_deliver_source         (o_deliver_source),
    .o_deliver_optics_channel (o_deliver_optics_channel),
    .o_deliver_value          (o_deliver_value)
);
